>>> hdl/parc_pkg.sv
// Shared types, widths and arithmetic step functions for the patch-aligned resize calculator.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package parc_pkg;

  // field widths
  localparam int unsigned DimW       = 16;
  localparam int unsigned FacW       = 11;
  localparam int unsigned CntW       = 28;
  localparam int unsigned OutW       = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RatioW     = 8;
  localparam int unsigned RatioLimit = 200;

  // register reset values
  localparam logic [FacW-1:0] FactorRst = FacW'(28);
  localparam logic [CntW-1:0] MinPixRst = CntW'(3136);
  localparam logic [CntW-1:0] MaxPixRst = CntW'(1003520);

  // derived datapath widths
  localparam int unsigned DimMaxW = (DimW > FacW) ? DimW : FacW;
  localparam int unsigned NumAW   = DimMaxW + 2;
  localparam int unsigned BaseW   = DimMaxW + 1;
  localparam int unsigned AreaW   = 2 * BaseW;
  localparam int unsigned CmpW    = (AreaW > CntW) ? AreaW : CntW;
  localparam int unsigned NumBW   = DimW + CntW;
  localparam int unsigned SqW     = (NumBW + 1) / 2;
  localparam int unsigned RadW    = 2 * SqW;
  localparam int unsigned RootW   = SqW + 1;
  localparam int unsigned FinW    = RootW + 1 + FacW;

  // queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FACTOR  = 2'd0,
    CFG_MIN_PIX = 2'd1,
    CFG_MAX_PIX = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DIM = 2'd1,
    ST_RATIO    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_KEEP   = 2'd0,
    MODE_SHRINK = 2'd1,
    MODE_GROW   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [DimW-1:0] in_height;
    logic [DimW-1:0] in_width;
  } in_item_t;

  typedef struct packed {
    logic [OutW-1:0] out_height;
    logic [OutW-1:0] out_width;
    status_e         status;
  } out_item_t;

  typedef struct packed {
    logic [FacW-1:0] factor;
    logic [CntW-1:0] min_pix;
    logic [CntW-1:0] max_pix;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
    status_e         status;
  } q_item_t;

  // per-item context carried down the back pipeline
  typedef struct packed {
    logic [DimW-1:0]  h;
    logic [DimW-1:0]  w;
    logic [BaseW-1:0] hb;
    logic [BaseW-1:0] wb;
    status_e          status;
    mode_e            mode;
  } ctx_t;

  typedef struct packed {
    logic [FacW:0]    rem;
    logic [NumAW-1:0] quo;
  } div_a_t;

  typedef struct packed {
    logic [DimW-1:0]  rem;
    logic [NumBW-1:0] quo;
  } div_b_t;

  typedef struct packed {
    logic [RadW-1:0] rad;
    logic [SqW:0]    rem;
    logic [SqW-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [FacW-1:0]  rem;
    logic [RootW-1:0] quo;
  } div_d_t;

  // one restoring step: rounding divide by twice the factor
  function automatic div_a_t div_a_step(div_a_t s, logic [FacW:0] dv);
    div_a_t          r;
    logic [FacW+1:0] tr;
    r = s;
    tr = {s.rem, s.quo[NumAW-1]};
    r.quo = {s.quo[NumAW-2:0], 1'b0};
    if (tr >= {1'b0, dv}) begin
      tr = tr - {1'b0, dv};
      r.quo[0] = 1'b1;
    end
    r.rem = tr[FacW:0];
    return r;
  endfunction

  // one restoring step: scaled area divided by the partner dimension
  function automatic div_b_t div_b_step(div_b_t s, logic [DimW-1:0] dv);
    div_b_t      r;
    logic [DimW:0] tr;
    r = s;
    tr = {s.rem, s.quo[NumBW-1]};
    r.quo = {s.quo[NumBW-2:0], 1'b0};
    if (tr >= {1'b0, dv}) begin
      tr = tr - {1'b0, dv};
      r.quo[0] = 1'b1;
    end
    r.rem = tr[DimW-1:0];
    return r;
  endfunction

  // one digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t        r;
    logic [SqW+2:0] tr;
    logic [SqW+2:0] trial;
    r = s;
    tr = {s.rem, s.rad[RadW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RadW-3:0], 2'b00};
    r.root = {s.root[SqW-2:0], 1'b0};
    if (tr >= trial) begin
      tr = tr - trial;
      r.root[0] = 1'b1;
    end
    r.rem = tr[SqW:0];
    return r;
  endfunction

  // one restoring step: root divided by the factor
  function automatic div_d_t div_d_step(div_d_t s, logic [FacW-1:0] dv);
    div_d_t      r;
    logic [FacW:0] tr;
    r = s;
    tr = {s.rem, s.quo[RootW-1]};
    r.quo = {s.quo[RootW-2:0], 1'b0};
    if (tr >= {1'b0, dv}) begin
      tr = tr - {1'b0, dv};
      r.quo[0] = 1'b1;
    end
    r.rem = tr[FacW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/parc_front.sv
// Front stage: accepts input items, flags zero size and extreme aspect ratio.
// Depends on parc_pkg; feeds parc_queue.
`timescale 1ns / 1ps
`default_nettype none

module parc_front import parc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          push_o,
  input  wire logic     full_i,
  output q_item_t       item_o
);

  logic                   vld_q, vld_d;
  q_item_t                item_q;
  q_item_t                item_d;
  logic [DimW-1:0]        hi, lo;
  logic [DimW+RatioW-1:0] lim;
  logic                   accept;

  // hold the item while the queue is full
  assign in_stall_o = vld_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~full_i;
  assign item_o     = item_q;

  // classify the incoming size
  assign hi  = (in_item_i.in_height > in_item_i.in_width) ? in_item_i.in_height
                                                          : in_item_i.in_width;
  assign lo  = (in_item_i.in_height > in_item_i.in_width) ? in_item_i.in_width
                                                          : in_item_i.in_height;
  assign lim = lo * RatioW'(RatioLimit);

  always_comb begin
    item_d.h = in_item_i.in_height;
    item_d.w = in_item_i.in_width;
    if ((in_item_i.in_height == '0) || (in_item_i.in_width == '0)) begin
      item_d.status = ST_ZERO_DIM;
    end else if ((DimW+RatioW)'(hi) > lim) begin
      item_d.status = ST_RATIO;
    end else begin
      item_d.status = ST_OK;
    end
  end

  // occupancy of the front register
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/parc_queue.sv
// Short fifo between the front stage and the arithmetic back end.
// Depends on parc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module parc_queue import parc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t item_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output q_item_t      item_o
);

  q_item_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // occupancy count
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> hdl/parc_back.sv
// Back end: pipelined rounding divide, area check, scaled divide, square root
// and final alignment for both dimensions. Depends on parc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module parc_back import parc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      q_valid_i,
  input  wire q_item_t   q_item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  // stage positions along the pipeline
  localparam int unsigned IaEnd  = NumAW;
  localparam int unsigned IM1    = IaEnd + 1;
  localparam int unsigned IM2    = IM1 + 1;
  localparam int unsigned IM3    = IM2 + 1;
  localparam int unsigned IB0    = IM3 + 1;
  localparam int unsigned IbEnd  = IB0 + NumBW;
  localparam int unsigned IcEnd  = IbEnd + 1 + SqW;
  localparam int unsigned IdEnd  = IcEnd + 1 + RootW;
  localparam int unsigned IOut   = IdEnd + 1;
  localparam int unsigned NSt    = IOut + 1;

  logic [NSt-1:0]         vld_q;
  logic                   adv;
  ctx_t                   ctx_q [IOut];
  ctx_t                   ctx_d [IOut];
  div_a_t                 a_q   [2][NumAW+1];
  div_b_t                 b_q   [2][NumBW+1];
  sqrt_t                  s_q   [2][SqW+1];
  div_d_t                 dd_q  [2][RootW+1];
  div_a_t                 a_init [2];
  div_b_t                 b_init [2];
  sqrt_t                  s_init [2];
  div_d_t                 dd_init [2];
  logic [NumAW+FacW-1:0]  base_prod [2];
  logic [AreaW-1:0]       area_q;
  logic [CntW-1:0]        bound;
  logic [FacW:0]          dv_a;
  logic [FinW-1:0]        fin [2];
  logic [FinW-1:0]        fin_sh, fin_gr, fin_keep;
  logic [RootW:0]         q_up;
  out_item_t              out_q, out_d;

  // whole pipeline moves unless the result register is held
  assign adv         = ~(vld_q[NSt-1] & out_stall_i);
  assign pop_o       = adv;
  assign out_valid_o = vld_q[NSt-1];
  assign out_item_o  = out_q;
  assign dv_a        = {cfg_i.factor, 1'b0};
  assign bound       = (ctx_q[IM3].mode == MODE_GROW) ? cfg_i.min_pix : cfg_i.max_pix;

  // context flow with updates at the rounding and mode stages
  always_comb begin
    ctx_d[0].h      = q_item_i.h;
    ctx_d[0].w      = q_item_i.w;
    ctx_d[0].hb     = '0;
    ctx_d[0].wb     = '0;
    ctx_d[0].status = q_item_i.status;
    ctx_d[0].mode   = MODE_KEEP;
    for (int i = 1; i < IOut; i++) begin
      ctx_d[i] = ctx_q[i-1];
    end
    for (int l = 0; l < 2; l++) begin
      base_prod[l] = a_q[l][NumAW].quo * cfg_i.factor;
    end
    ctx_d[IM1].hb = base_prod[0][BaseW-1:0];
    ctx_d[IM1].wb = base_prod[1][BaseW-1:0];
    if (CmpW'(area_q) > CmpW'(cfg_i.max_pix)) begin
      ctx_d[IM3].mode = MODE_SHRINK;
    end else if (CmpW'(area_q) < CmpW'(cfg_i.min_pix)) begin
      ctx_d[IM3].mode = MODE_GROW;
    end else begin
      ctx_d[IM3].mode = MODE_KEEP;
    end
  end

  // entry values of each iterative unit
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_init[l].rem = '0;
      a_init[l].quo = (NumAW'((l == 0) ? q_item_i.h : q_item_i.w) << 1)
                      + NumAW'(cfg_i.factor);
      b_init[l].rem = '0;
      b_init[l].quo = ((l == 0) ? ctx_q[IM3].h : ctx_q[IM3].w) * bound;
      s_init[l].rem  = '0;
      s_init[l].root = '0;
      s_init[l].rad  = RadW'(b_q[l][NumBW].quo
                       + NumBW'((ctx_q[IbEnd].mode == MODE_GROW)
                                && (b_q[l][NumBW].rem != '0)));
      dd_init[l].rem = '0;
      dd_init[l].quo = RootW'(s_q[l][SqW].root)
                       + RootW'((ctx_q[IcEnd].mode == MODE_GROW)
                                && (s_q[l][SqW].rem != '0));
    end
  end

  // final alignment to the factor
  always_comb begin
    fin_sh   = '0;
    fin_gr   = '0;
    fin_keep = '0;
    q_up     = '0;
    for (int l = 0; l < 2; l++) begin
      fin_sh   = dd_q[l][RootW].quo * cfg_i.factor;
      if (fin_sh < FinW'(cfg_i.factor)) begin
        fin_sh = FinW'(cfg_i.factor);
      end
      q_up     = {1'b0, dd_q[l][RootW].quo} + (RootW+1)'(dd_q[l][RootW].rem != '0);
      fin_gr   = q_up * cfg_i.factor;
      fin_keep = FinW'((l == 0) ? ctx_q[IdEnd].hb : ctx_q[IdEnd].wb);
      case (ctx_q[IdEnd].mode)
        MODE_SHRINK: fin[l] = fin_sh;
        MODE_GROW:   fin[l] = fin_gr;
        default:     fin[l] = fin_keep;
      endcase
    end
  end

  always_comb begin
    out_d.status = ctx_q[IdEnd].status;
    if (ctx_q[IdEnd].status == ST_OK) begin
      out_d.out_height = fin[0][OutW-1:0];
      out_d.out_width  = fin[1][OutW-1:0];
    end else begin
      out_d.out_height = '0;
      out_d.out_width  = '0;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], q_valid_i};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < IOut; i++) begin
        ctx_q[i] <= ctx_d[i];
      end
      area_q <= ctx_q[IM1].hb * ctx_q[IM1].wb;
      for (int l = 0; l < 2; l++) begin
        a_q[l][0] <= a_init[l];
        for (int k = 0; k < NumAW; k++) begin
          a_q[l][k+1] <= div_a_step(a_q[l][k], dv_a);
        end
        b_q[l][0] <= b_init[l];
        for (int k = 0; k < NumBW; k++) begin
          b_q[l][k+1] <= div_b_step(b_q[l][k],
                                    (l == 0) ? ctx_q[IB0+k].w : ctx_q[IB0+k].h);
        end
        s_q[l][0] <= s_init[l];
        for (int k = 0; k < SqW; k++) begin
          s_q[l][k+1] <= sqrt_step(s_q[l][k]);
        end
        dd_q[l][0] <= dd_init[l];
        for (int k = 0; k < RootW; k++) begin
          dd_q[l][k+1] <= div_d_step(dd_q[l][k], cfg_i.factor);
        end
      end
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSt-1] && (out_q.status != ST_OK))
      |-> ((out_q.out_height == '0) && (out_q.out_width == '0)))
    else $error("error result with nonzero size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSt-1] && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while result held");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSt-2] && adv) |=> vld_q[NSt-1])
    else $error("item lost at result register");
`endif

endmodule

`default_nettype wire

>>> hdl/patch_aligned_image_resize_calc_unit.sv
// Top level of the patch-aligned resize calculator: config registers, front,
// queue and back end. Depends on parc_pkg, parc_front, parc_queue, parc_back.
//
//   port group   dir  handshake               payload
//   in_*         in   in_valid_i/in_stall_o   in_item_i (height, width)
//   out_*        out  out_valid_o/out_stall_i out_item_o (height, width, status)
//   cfg_*        in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the result is not held; each item passes through
// the bit-per-stage dividers and the digit-per-stage square root.
// Reset is asynchronous, active low; it empties every stage and loads the
// default factor and pixel bounds.
// A held result freezes the whole back pipeline; the four-entry queue and the
// front register keep accepting until they fill.
`timescale 1ns / 1ps
`default_nettype none

module patch_aligned_image_resize_calc_unit import parc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_item_t            out_item_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CntW-1:0] cfg_wdata_i
);

  logic [FacW-1:0] factor_q;
  logic [CntW-1:0] min_pix_q;
  logic [CntW-1:0] max_pix_q;
  cfg_t            cfg;
  logic            push, full, q_valid, pop;
  q_item_t         fr_item, q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q  <= FactorRst;
      min_pix_q <= MinPixRst;
      max_pix_q <= MaxPixRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FACTOR:  factor_q  <= cfg_wdata_i[FacW-1:0];
        CFG_MIN_PIX: min_pix_q <= cfg_wdata_i;
        CFG_MAX_PIX: max_pix_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a zero factor acts as one
  assign cfg.factor  = (factor_q == '0) ? FacW'(1) : factor_q;
  assign cfg.min_pix = min_pix_q;
  assign cfg.max_pix = max_pix_q;

  parc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (fr_item)
  );

  parc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  parc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for the patch-aligned resize calculator top level.
// Depends on parc_pkg and patch_aligned_image_resize_calc_unit; predicts each result itself.
`timescale 1ns / 1ps

module testbench;
  import parc_pkg::*;

  // clock, reset and block ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CntW-1:0]     cfg_wdata = '0;

  // predictor copy of the registers
  longint unsigned grid_f = 28;
  longint unsigned min_pix = 3136;
  longint unsigned max_pix = 1003520;

  out_item_t target_q[$];
  int        errors = 0;
  int        burst_left = 0;

  // one directed row; typed expectation only where obvious
  typedef struct {
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
    bit              typed;
    logic [OutW-1:0] eh;
    logic [OutW-1:0] ew;
    status_e         st;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{16'd0,     16'd5,     1'b1, 20'd0,   20'd0,   ST_ZERO_DIM},
    '{16'd5,     16'd0,     1'b1, 20'd0,   20'd0,   ST_ZERO_DIM},
    '{16'd0,     16'd0,     1'b1, 20'd0,   20'd0,   ST_ZERO_DIM},
    '{16'd65535, 16'd1,     1'b1, 20'd0,   20'd0,   ST_RATIO},
    '{16'd1,     16'd65535, 1'b1, 20'd0,   20'd0,   ST_RATIO},
    '{16'd201,   16'd1,     1'b1, 20'd0,   20'd0,   ST_RATIO},
    '{16'd1,     16'd201,   1'b1, 20'd0,   20'd0,   ST_RATIO},
    '{16'd224,   16'd224,   1'b1, 20'd224, 20'd224, ST_OK},
    '{16'd200,   16'd1,     1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd1,     16'd200,   1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd65535, 16'd65535, 1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd65535, 16'd327,   1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd1,     16'd1,     1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd14,    16'd42,    1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd13,    16'd41,    1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd1000,  16'd1003,  1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd32768, 16'd16384, 1'b0, 20'd0,   20'd0,   ST_OK},
    '{16'd21845, 16'd43690, 1'b0, 20'd0,   20'd0,   ST_OK}
  };

  patch_aligned_image_resize_calc_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor square root by bit search
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // downscale one dimension to fit the upper bound
  function automatic longint unsigned shrink_side(longint unsigned d, longint unsigned p,
                                                  longint unsigned f);
    longint unsigned v;
    v = (floor_root((d * max_pix) / p) / f) * f;
    return (v < f) ? f : v;
  endfunction

  // upscale one dimension to reach the lower bound
  function automatic longint unsigned grow_side(longint unsigned d, longint unsigned p,
                                                longint unsigned f);
    longint unsigned q, r;
    q = (d * min_pix + p - 1) / p;
    r = floor_root(q);
    if (r * r < q) r++;
    return ((r + f - 1) / f) * f;
  endfunction

  // expected target size for one source size
  function automatic out_item_t resize_target(logic [DimW-1:0] h, logic [DimW-1:0] w);
    out_item_t       r;
    longint unsigned hh, ww, f, hb, wb;
    r = '0;
    r.status = ST_OK;
    hh = h;
    ww = w;
    f = (grid_f == 0) ? 1 : grid_f;
    if (hh == 0 || ww == 0) begin
      r.status = ST_ZERO_DIM;
      return r;
    end
    if ((hh > ww ? hh : ww) > 200 * (hh > ww ? ww : hh)) begin
      r.status = ST_RATIO;
      return r;
    end
    hb = ((2 * hh + f) / (2 * f)) * f;
    wb = ((2 * ww + f) / (2 * f)) * f;
    if (hb * wb > max_pix) begin
      hb = shrink_side(hh, ww, f);
      wb = shrink_side(ww, hh, f);
    end else if (hb * wb < min_pix) begin
      hb = grow_side(hh, ww, f);
      wb = grow_side(ww, hh, f);
    end
    r.out_height = hb[OutW-1:0];
    r.out_width  = wb[OutW-1:0];
    return r;
  endfunction

  // offer one item in bursts with gaps, record its expectation on acceptance
  task automatic send_size(logic [DimW-1:0] h, logic [DimW-1:0] w, bit typed,
                           out_item_t typed_res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_item.in_height <= h;
    in_item.in_width  <= w;
    do @(posedge clk); while (in_stall);
    target_q.push_back(typed ? typed_res : resize_target(h, w));
    burst_left--;
  endtask

  // drain everything, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (target_q.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic load_config(longint unsigned f, longint unsigned mn, longint unsigned mx);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FACTOR;
    cfg_wdata <= CntW'(f);
    @(posedge clk);
    grid_f = f & 64'h7ff;
    cfg_idx <= CFG_MIN_PIX;
    cfg_wdata <= CntW'(mn);
    @(posedge clk);
    min_pix = mn & 64'hfffffff;
    cfg_idx <= CFG_MAX_PIX;
    cfg_wdata <= CntW'(mx);
    @(posedge clk);
    max_pix = mx & 64'hfffffff;
    cfg_we <= 1'b0;
  endtask

  // random source size: mostly valid, some zero and near the ratio limit
  task automatic random_size(output logic [DimW-1:0] h, output logic [DimW-1:0] w);
    int unsigned m, lo;
    m = $urandom_range(0, 19);
    h = DimW'($urandom_range(1, 2048));
    w = DimW'($urandom_range(1, 2048));
    if (m == 0) h = 0;
    else if (m == 1) w = 0;
    else if (m == 2) begin
      lo = $urandom_range(1, 327);
      h = DimW'(lo * 200 + $urandom_range(0, 1));
      w = DimW'(lo);
      if ($urandom_range(0, 1)) begin
        w = h;
        h = DimW'(lo);
      end
    end else if (m <= 5) begin
      h = DimW'($urandom);
      w = DimW'($urandom);
    end else if (m == 6) begin
      h = DimW'($urandom_range(1, 64));
      w = DimW'($urandom_range(1, 64));
    end
  endtask

  // receiver stall pattern: free, light, heavy, long holds
  initial begin
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 2);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (target_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        exp_res = target_q.pop_front();
        if (out_item.out_height !== exp_res.out_height) begin
          $display("%0t: out_height expected %0d got %0d", $time, exp_res.out_height,
                   out_item.out_height);
          errors++;
        end
        if (out_item.out_width !== exp_res.out_width) begin
          $display("%0t: out_width expected %0d got %0d", $time, exp_res.out_width,
                   out_item.out_width);
          errors++;
        end
        if (out_item.status !== exp_res.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_res.status,
                   out_item.status);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [DimW-1:0] h, w;
    out_item_t       typed_res;
    longint unsigned phase_cfg[7][3];
    phase_cfg = '{'{28, 3136, 1003520}, '{1, 1, 268435455}, '{1024, 268435455, 268435455},
                  '{0, 0, 0}, '{14, 50000, 200000}, '{0, 0, 0}, '{1024, 1, 1}};
    phase_cfg[5][0] = $urandom_range(1, 64);
    phase_cfg[5][1] = $urandom_range(1, 100000);
    phase_cfg[5][2] = $urandom_range(100000, 4000000);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset configuration
    foreach (dir_rows[i]) begin
      typed_res.out_height = dir_rows[i].eh;
      typed_res.out_width  = dir_rows[i].ew;
      typed_res.status     = dir_rows[i].st;
      send_size(dir_rows[i].h, dir_rows[i].w, dir_rows[i].typed, typed_res);
    end

    // random items over several register settings
    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        wait_drained();
        load_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      end
      repeat (62) begin
        random_size(h, w);
        send_size(h, w, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (target_q.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/parc_pkg.sv
hdl/parc_front.sv
hdl/parc_queue.sv
hdl/parc_back.sv
hdl/patch_aligned_image_resize_calc_unit.sv
tb/sv/testbench.sv
